/* design/scan_object_edge_detector_assert.svh */
// Assertion macros used by the port-level checker of the edge detector.
// Plain text macros only; no dependencies.
`ifndef SCAN_OBJECT_EDGE_DETECTOR_ASSERT_SVH
`define SCAN_OBJECT_EDGE_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checks what holds in the cycle after reset is seen low.
`define SOED_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

/* design/soed_pkg.sv */
// Shared types and constants of the scan object edge detector.
// No dependencies; used by the channel interfaces and all modules.
package soed_pkg;

  localparam int ANGLE_W  = 8;
  localparam int SAMPLE_W = 12;
  localparam int THR_W    = 12;
  localparam int MINW_W   = 8;
  localparam int COUNT_W  = 5;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  // Register indexes; each register sits at byte address 4 * index.
  localparam logic [REG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_FLOOR   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_WIDTH      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_OBJECTS    = 2'd3;

  localparam logic [THR_W-1:0]    EDGE_THRESHOLD_RST = 12'd90;
  localparam logic [SAMPLE_W-1:0] SAMPLE_FLOOR_RST   = 12'd400;
  localparam logic [MINW_W-1:0]   MIN_WIDTH_RST      = 8'd4;
  localparam logic [COUNT_W-1:0]  MAX_OBJECTS_RST    = 5'd15;

  typedef struct packed {
    logic [THR_W-1:0]    edge_threshold;
    logic [SAMPLE_W-1:0] sample_floor;
    logic [MINW_W-1:0]   min_width;
    logic [COUNT_W-1:0]  max_objects;
  } soed_cfg_t;

endpackage

/* design/soed_channels.sv */
// Valid/ready channel interfaces for sensor samples and object reports.
// Depends on soed_pkg for field widths.
interface soed_in_if;
  logic                           valid;
  logic                           ready;
  logic [soed_pkg::ANGLE_W-1:0]   angle;
  logic [soed_pkg::SAMPLE_W-1:0]  sample;
  logic                           sweep_start;
  logic                           sweep_end;

  modport source (output valid, output angle, output sample, output sweep_start,
                  output sweep_end, input ready);
  modport sink (input valid, input angle, input sample, input sweep_start,
                input sweep_end, output ready);
endinterface

interface soed_out_if;
  logic                          valid;
  logic                          ready;
  logic [soed_pkg::ANGLE_W-1:0]  start_angle;
  logic [soed_pkg::ANGLE_W-1:0]  end_angle;
  logic [soed_pkg::ANGLE_W-1:0]  mid_angle;
  logic [soed_pkg::COUNT_W-1:0]  object_number;
  logic                          closed_by_end;

  modport source (output valid, output start_angle, output end_angle,
                  output mid_angle, output object_number, output closed_by_end,
                  input ready);
  modport sink (input valid, input start_angle, input end_angle, input mid_angle,
                input object_number, input closed_by_end, output ready);
endinterface

/* design/soed_cfg_regs.sv */
// APB-style configuration registers of the edge detector.
// Depends on soed_pkg for register indexes, reset values and soed_cfg_t.
module soed_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [soed_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [soed_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [soed_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output soed_pkg::soed_cfg_t               cfg
);

  soed_pkg::soed_cfg_t             cfg_r;
  soed_pkg::soed_cfg_t             cfg_nxt;
  logic                            wr_en;
  logic [soed_pkg::REG_IDX_W-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[soed_pkg::CFG_ADDR_W-1:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        soed_pkg::REG_EDGE_THRESHOLD:
          cfg_nxt.edge_threshold = pwdata[soed_pkg::THR_W-1:0];
        soed_pkg::REG_SAMPLE_FLOOR:
          cfg_nxt.sample_floor = pwdata[soed_pkg::SAMPLE_W-1:0];
        soed_pkg::REG_MIN_WIDTH:
          cfg_nxt.min_width = pwdata[soed_pkg::MINW_W-1:0];
        soed_pkg::REG_MAX_OBJECTS:
          cfg_nxt.max_objects = pwdata[soed_pkg::COUNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      soed_pkg::REG_EDGE_THRESHOLD:
        prdata = soed_pkg::CFG_DATA_W'(cfg_r.edge_threshold);
      soed_pkg::REG_SAMPLE_FLOOR:
        prdata = soed_pkg::CFG_DATA_W'(cfg_r.sample_floor);
      soed_pkg::REG_MIN_WIDTH:
        prdata = soed_pkg::CFG_DATA_W'(cfg_r.min_width);
      soed_pkg::REG_MAX_OBJECTS:
        prdata = soed_pkg::CFG_DATA_W'(cfg_r.max_objects);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.edge_threshold <= soed_pkg::EDGE_THRESHOLD_RST;
      cfg_r.sample_floor   <= soed_pkg::SAMPLE_FLOOR_RST;
      cfg_r.min_width      <= soed_pkg::MIN_WIDTH_RST;
      cfg_r.max_objects    <= soed_pkg::MAX_OBJECTS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* design/soed_core.sv */
// Detection datapath: input register, sample ring with running sum,
// edge tracking and the result register.
// Depends on soed_pkg and the channel interfaces in soed_channels.sv.
module soed_core #(
  parameter int WINDOW = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  soed_pkg::soed_cfg_t  cfg,
  soed_in_if.sink              in_ch,
  soed_out_if.source           out_ch
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = soed_pkg::SAMPLE_W + $clog2(WINDOW);
  // Reciprocal of WINDOW; with this shift the product gives the exact floor
  // for every sum that fits in SUM_W bits.
  localparam int DIV_SH = SUM_W + $clog2(WINDOW);
  localparam int MUL_W  = SUM_W + 2;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam longint unsigned DIV_MUL_L =
    ((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(DIV_MUL_L);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

  localparam int AW = soed_pkg::ANGLE_W;
  localparam int SW = soed_pkg::SAMPLE_W;
  localparam int CW = soed_pkg::COUNT_W;

  // Input register
  logic          s1_v_r, s1_v_nxt;
  logic [AW-1:0] s1_angle_r;
  logic [SW-1:0] s1_sample_r;
  logic          s1_start_r, s1_end_r;
  logic          in_acc, s1_go;

  // Sweep state
  logic [SW-1:0]    win_r [WINDOW];
  logic [SLOT_W-1:0] slot_r, slot_nxt, slot_cur;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_cur;
  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_cur;
  logic              in_obj_r, in_obj_nxt, in_obj_cur;
  logic [AW-1:0]     open_start_r, open_start_nxt;
  logic [CW-1:0]     found_r, found_nxt, found_cur;

  // Result register
  logic          out_v_r, out_v_nxt;
  logic [AW-1:0] out_start_r, out_end_r, out_mid_r;
  logic [CW-1:0] out_num_r;
  logic          out_by_end_r;

  // Datapath
  logic [SW-1:0]         clamped;
  logic                  filling;
  logic [PROD_W-1:0]     prod;
  logic [SW-1:0]         avg;
  logic signed [SW+1:0]  change;
  logic signed [SW+1:0]  thr_s;
  logic                  rise, fall;
  logic                  rise_open, fall_close, fall_report, open_after;
  logic                  emit, report;
  logic signed [AW:0]    obj_width;
  logic signed [AW:0]    half_width;
  logic [AW:0]           mid_full;
  logic                  narrow;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign s1_go        = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || s1_go;
  assign s1_v_nxt     = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);

  // A sweep start clears the state before this sample is handled.
  assign slot_cur   = s1_start_r ? '0 : slot_r;
  assign fill_cur   = s1_start_r ? '0 : fill_r;
  assign sum_cur    = s1_start_r ? '0 : sum_r;
  assign in_obj_cur = s1_start_r ? 1'b0 : in_obj_r;
  assign found_cur  = s1_start_r ? '0 : found_r;

  assign clamped  = (s1_sample_r < cfg.sample_floor) ? cfg.sample_floor : s1_sample_r;
  assign filling  = fill_cur < FILL_FULL;
  assign slot_nxt = (slot_cur == SLOT_LAST) ? '0 : slot_cur + 1'b1;
  assign fill_nxt = filling ? fill_cur + 1'b1 : fill_cur;

  // Running sum of the ring; once full the overwritten entry drops out.
  always_comb begin
    if (filling) begin
      sum_nxt = sum_cur + SUM_W'(clamped);
    end else begin
      sum_nxt = sum_cur - SUM_W'(win_r[slot_cur]) + SUM_W'(clamped);
    end
  end

  assign prod   = PROD_W'(sum_nxt) * PROD_W'(DIV_MUL);
  assign avg    = prod[DIV_SH +: SW];
  assign change = $signed({2'b00, clamped}) - $signed({2'b00, avg});
  assign thr_s  = $signed({2'b00, cfg.edge_threshold});
  assign rise   = change > thr_s;
  assign fall   = change < -thr_s;

  assign rise_open      = !filling && !in_obj_cur && rise;
  assign fall_close     = !filling && in_obj_cur && fall;
  assign open_start_nxt = rise_open ? s1_angle_r : open_start_r;
  assign open_after     = rise_open || (in_obj_cur && !fall_close);

  assign obj_width   = $signed({1'b0, s1_angle_r}) - $signed({1'b0, open_start_nxt});
  assign narrow      = obj_width < $signed({1'b0, cfg.min_width});
  assign fall_report = fall_close && !narrow;
  assign emit        = fall_report || (s1_end_r && open_after);
  assign report      = emit && (found_cur < cfg.max_objects);
  assign in_obj_nxt  = emit ? 1'b0 : open_after;
  assign found_nxt   = report ? found_cur + 1'b1 : found_cur;

  // Half width, truncated toward zero.
  assign half_width = (obj_width + $signed({{AW{1'b0}}, obj_width[AW]})) >>> 1;
  assign mid_full   = {1'b0, open_start_nxt} + half_width;

  assign out_v_nxt = s1_go ? report : (out_v_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      slot_r       <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      in_obj_r     <= 1'b0;
      open_start_r <= '0;
      found_r      <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_go) begin
        slot_r       <= slot_nxt;
        fill_r       <= fill_nxt;
        sum_r        <= sum_nxt;
        in_obj_r     <= in_obj_nxt;
        open_start_r <= open_start_nxt;
        found_r      <= found_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_angle_r  <= in_ch.angle;
      s1_sample_r <= in_ch.sample;
      s1_start_r  <= in_ch.sweep_start;
      s1_end_r    <= in_ch.sweep_end;
    end
    if (s1_go) begin
      win_r[slot_cur] <= clamped;
    end
    if (s1_go && report) begin
      out_start_r  <= open_start_nxt;
      out_end_r    <= s1_angle_r;
      out_mid_r    <= mid_full[AW-1:0];
      out_num_r    <= found_cur;
      out_by_end_r <= !fall_report;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.start_angle   = out_start_r;
  assign out_ch.end_angle     = out_end_r;
  assign out_ch.mid_angle     = out_mid_r;
  assign out_ch.object_number = out_num_r;
  assign out_ch.closed_by_end = out_by_end_r;

endmodule

/* design/scan_object_edge_detector.sv */
// Scan object edge detector: takes one range sample per sweep angle and reports
// each object found as a start, end and middle angle. It accepts one item per
// clock cycle unless a stalled result holds the pipeline; a report passes the
// input register, then the result register, and waits there until it is taken.
// The cycle is bounded by the running window sum followed by the reciprocal
// multiply that forms the window average and the threshold compare. No clearing
// pass is needed after reset. A stalled result holds the pipeline only once the
// input register is also occupied.
// Depends on soed_pkg, soed_channels.sv, soed_cfg_regs and soed_core.
module scan_object_edge_detector #(
  parameter int WINDOW = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  soed_in_if.sink                          in_ch,
  soed_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [soed_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [soed_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [soed_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  soed_pkg::soed_cfg_t cfg;

  soed_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  soed_core #(
    .WINDOW (WINDOW)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

/* design/soed_checker.sv */
// Port-level checks of the edge detector, attached to the top level by bind.
// Depends on scan_object_edge_detector_assert.svh and soed_pkg.
`include "scan_object_edge_detector_assert.svh"

module soed_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [soed_pkg::ANGLE_W-1:0]   start_angle,
  input logic [soed_pkg::ANGLE_W-1:0]   end_angle,
  input logic [soed_pkg::ANGLE_W-1:0]   mid_angle,
  input logic [soed_pkg::COUNT_W-1:0]   object_number,
  input logic                           closed_by_end
);

  `SOED_ASSERT_AFTER_RESET(a_no_result_after_reset, clk, rst_n, !out_valid, "result valid right after reset")

  `SOED_ASSERT_NEXT(a_stalled_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(start_angle) && $stable(end_angle) && $stable(mid_angle) && $stable(object_number) && $stable(closed_by_end), "stalled result changed")

  `SOED_ASSERT_IMPL(a_ready_when_drained, clk, rst_n, !out_valid, in_ready, "input stalled with no result pending")

  // An object closed by a falling edge has a width of at least zero.
  `SOED_ASSERT_IMPL(a_edge_close_ordered, clk, rst_n, out_valid && !closed_by_end, (start_angle <= mid_angle) && (mid_angle <= end_angle), "edge-closed object angles out of order")

endmodule

bind scan_object_edge_detector soed_checker u_soed_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .start_angle   (out_ch.start_angle),
  .end_angle     (out_ch.end_angle),
  .mid_angle     (out_ch.mid_angle),
  .object_number (out_ch.object_number),
  .closed_by_end (out_ch.closed_by_end)
);

/* tb/tb_scan_object_edge_detector.sv */
// Self-checking testbench for scan_object_edge_detector: directed sweeps from a table,
// then random sweeps under changing register settings, all checked by a local predictor.
// Depends on soed_pkg, the channel interfaces in soed_channels.sv and the block itself.
module tb_scan_object_edge_detector;
  import soed_pkg::*;

  localparam int WIN         = 5;
  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 115;
  localparam int DIR_ROWS    = 28;

  typedef struct packed {
    logic [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0] end_angle;
    logic [ANGLE_W-1:0] mid_angle;
    logic [COUNT_W-1:0] object_number;
    logic               closed_by_end;
  } report_t;

  // ROW_ITEM rows are checked by the predictor alone, ROW_QUIET rows expect no report,
  // ROW_TYPED rows carry their report, and ROW_CFG rows write a register.
  typedef enum logic [1:0] {ROW_ITEM, ROW_QUIET, ROW_TYPED, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [ANGLE_W-1:0]   angle;
    logic [SAMPLE_W-1:0]  sample;  // register value on ROW_CFG rows
    logic                 sweep_start;
    logic                 sweep_end;
    report_t              report;
  } dir_row_t;

  localparam report_t NO_REPORT = '0;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Sweep start, then four more low samples that only fill the window.
    '{ROW_QUIET, '0, 8'd0,   12'd0,    1'b1, 1'b0, NO_REPORT},
    '{ROW_QUIET, '0, 8'd1,   12'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_QUIET, '0, 8'd2,   12'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_QUIET, '0, 8'd3,   12'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_QUIET, '0, 8'd4,   12'd0,    1'b0, 1'b0, NO_REPORT},
    // Rise, then a fall one degree later that is too narrow to report; then a wider object that is reported.
    '{ROW_ITEM,  '0, 8'd5,   12'd4095, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd6,   12'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd10,  12'd4095, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd30,  12'd0,    1'b0, 1'b0, NO_REPORT},
    // The angle runs backwards: a falling edge discards, a sweep end reports.
    '{ROW_ITEM,  '0, 8'd40,  12'd4095, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd20,  12'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd50,  12'd4095, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd30,  12'd4095, 1'b0, 1'b1, NO_REPORT},
    // The next sweep carries on without a start; the window stays primed.
    '{ROW_ITEM,  '0, 8'd60,  12'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd61,  12'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd62,  12'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd63,  12'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd64,  12'd0,    1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd65,  12'd4095, 1'b0, 1'b0, NO_REPORT},
    // A falling edge on the last sample reports, and a narrow one there is dropped.
    '{ROW_ITEM,  '0, 8'd180, 12'd0,    1'b0, 1'b1, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd100, 12'd4095, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd101, 12'd0,    1'b0, 1'b1, NO_REPORT},
    // A rise on the last sample is closed at once; the limit then holds back more.
    '{ROW_CFG,   REG_MAX_OBJECTS, 8'd0, 12'd4, 1'b0, 1'b0, NO_REPORT},
    '{ROW_TYPED, '0, 8'd5,   12'd4095, 1'b0, 1'b1, '{8'd5, 8'd5, 8'd5, 5'd3, 1'b1}},
    '{ROW_ITEM,  '0, 8'd7,   12'd4095, 1'b0, 1'b0, NO_REPORT},
    '{ROW_ITEM,  '0, 8'd12,  12'd0,    1'b0, 1'b1, NO_REPORT},
    // With a limit of zero nothing is ever reported.
    '{ROW_CFG,   REG_MAX_OBJECTS, 8'd0, 12'd0, 1'b0, 1'b0, NO_REPORT},
    '{ROW_QUIET, '0, 8'd20,  12'd4095, 1'b0, 1'b1, NO_REPORT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  soed_in_if  in_ch ();
  soed_out_if out_ch ();

  scan_object_edge_detector DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers and of the sweep state.
  soed_cfg_t           cfg_model;
  logic [SAMPLE_W-1:0] ring [WIN];
  int                  ring_slot;
  int                  ring_fill;
  int                  found_objects;
  bit                  tracking;
  logic [ANGLE_W-1:0]  open_angle;

  report_t pending_objects [$];
  int      error_count = 0;
  int      stall_left = 0;
  int      cycle_count = 0;
  int      idle_cycles = 0;

  always #5 clk = ~clk;

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic bit close_object(input logic [ANGLE_W-1:0] ang, input bit by_end,
                                      output report_t rep);
    int span;
    int mid;
    span = int'(ang) - int'(open_angle);
    mid = int'(open_angle) + span / 2;
    tracking = 1'b0;
    rep = NO_REPORT;
    if (found_objects >= int'(cfg_model.max_objects)) begin
      return 1'b0;
    end
    rep.start_angle   = open_angle;
    rep.end_angle     = ang;
    rep.mid_angle     = mid[ANGLE_W-1:0];
    rep.object_number = found_objects[COUNT_W-1:0];
    rep.closed_by_end = by_end;
    found_objects++;
    return 1'b1;
  endfunction

  function automatic bit track_sample(input logic [ANGLE_W-1:0] ang,
                                      input logic [SAMPLE_W-1:0] raw,
                                      input bit sw_start, input bit sw_end,
                                      output report_t rep);
    logic [SAMPLE_W-1:0] level;
    bit                  filling;
    int                  total;
    int                  change;
    int                  thr;
    int                  span;
    rep = NO_REPORT;
    if (sw_start) begin
      ring_slot = 0;
      ring_fill = 0;
      tracking = 1'b0;
      found_objects = 0;
    end
    level = (raw < cfg_model.sample_floor) ? cfg_model.sample_floor : raw;
    ring[ring_slot] = level;
    ring_slot = (ring_slot == WIN - 1) ? 0 : ring_slot + 1;
    filling = ring_fill < WIN;
    if (filling) begin
      ring_fill++;
    end else begin
      total = 0;
      for (int i = 0; i < WIN; i++) begin
        total += int'(ring[i]);
      end
      change = int'(level) - total / WIN;
      thr = int'(cfg_model.edge_threshold);
      if (!tracking && change > thr) begin
        tracking = 1'b1;
        open_angle = ang;
      end else if (tracking && change < -thr) begin
        span = int'(ang) - int'(open_angle);
        if (span < int'(cfg_model.min_width)) begin
          tracking = 1'b0;
        end else begin
          return close_object(ang, 1'b0, rep);
        end
      end
    end
    if (sw_end && tracking) begin
      return close_object(ang, 1'b1, rep);
    end
    return 1'b0;
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 25);
  endfunction

  // Called at a rising edge; returns at the edge where the item was accepted.
  task automatic send_sample(input logic [ANGLE_W-1:0] ang, input logic [SAMPLE_W-1:0] smp,
                             input bit sw_start, input bit sw_end, input int gap,
                             input row_kind_e kind, input report_t typed_rep);
    report_t rep;
    bit      has_rep;
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.angle       <= ang;
    in_ch.sample      <= smp;
    in_ch.sweep_start <= sw_start;
    in_ch.sweep_end   <= sw_end;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    has_rep = track_sample(ang, smp, sw_start, sw_end, rep);
    if (kind == ROW_ITEM) begin
      if (has_rep) begin
        pending_objects.push_back(rep);
      end
    end else begin
      if (has_rep != (kind == ROW_TYPED) || (has_rep && rep !== typed_rep)) begin
        flag_error($sformatf("directed row at angle %0d disagrees with the predictor", ang));
      end
      if (kind == ROW_TYPED) begin
        pending_objects.push_back(typed_rep);
      end
    end
  endtask

  // Stops the sender and waits for every awaited report, then for extra cycles.
  task automatic settle(input int extra);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_objects.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Writes one register and reads it back; the block must be idle.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] stored;
    stored = '0;
    case (idx)
      REG_EDGE_THRESHOLD: begin
        stored[THR_W-1:0] = value[THR_W-1:0];
        cfg_model.edge_threshold = value[THR_W-1:0];
      end
      REG_SAMPLE_FLOOR: begin
        stored[SAMPLE_W-1:0] = value[SAMPLE_W-1:0];
        cfg_model.sample_floor = value[SAMPLE_W-1:0];
      end
      REG_MIN_WIDTH: begin
        stored[MINW_W-1:0] = value[MINW_W-1:0];
        cfg_model.min_width = value[MINW_W-1:0];
      end
      default: begin
        stored[COUNT_W-1:0] = value[COUNT_W-1:0];
        cfg_model.max_objects = value[COUNT_W-1:0];
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== stored) begin
      flag_error($sformatf("register %0d read back %0d, expected %0d", idx, prdata, stored));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stalls, short mostly, with calm stretches without any.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ((cycle_count / 1500) % 4 != 3 && $urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                                                    $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.start_angle, out_ch.end_angle, out_ch.mid_angle,
              out_ch.object_number, out_ch.closed_by_end};
      if (pending_objects.size() == 0) begin
        flag_error($sformatf("unexpected report: start %0d end %0d mid %0d number %0d end %0d",
                             got.start_angle, got.end_angle, got.mid_angle,
                             got.object_number, got.closed_by_end));
      end else begin
        want = pending_objects.pop_front();
        if (got.start_angle !== want.start_angle || got.end_angle !== want.end_angle ||
            got.mid_angle !== want.mid_angle || got.object_number !== want.object_number ||
            got.closed_by_end !== want.closed_by_end) begin
          flag_error($sformatf({"report mismatch: expected %0d/%0d/%0d #%0d end %0d, ",
                                "got %0d/%0d/%0d #%0d end %0d"},
                               want.start_angle, want.end_angle, want.mid_angle,
                               want.object_number, want.closed_by_end,
                               got.start_angle, got.end_angle, got.mid_angle,
                               got.object_number, got.closed_by_end));
        end
      end
    end
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || psel === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL scan_object_edge_detector");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  sent;
    int  len;
    int  n;
    int  ang;
    int  step;
    int  bg;
    int  top;
    int  level;
    bit  backwards;
    bit  on_object;
    bit  burst;
    bit  with_start;
    bit  with_end;
    int  thr_v;
    int  floor_v;
    int  minw_v;
    int  maxobj_v;

    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.angle       <= '0;
    in_ch.sample      <= '0;
    in_ch.sweep_start <= 1'b0;
    in_ch.sweep_end   <= 1'b0;

    cfg_model = '{EDGE_THRESHOLD_RST, SAMPLE_FLOOR_RST, MIN_WIDTH_RST, MAX_OBJECTS_RST};
    for (int i = 0; i < WIN; i++) begin
      ring[i] = '0;
    end
    ring_slot = 0;
    ring_fill = 0;
    found_objects = 0;
    tracking = 1'b0;
    open_angle = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        settle(6);
        write_register(DIRECTED[r].reg_idx, int'(DIRECTED[r].sample));
      end else begin
        send_sample(DIRECTED[r].angle, DIRECTED[r].sample, DIRECTED[r].sweep_start,
                    DIRECTED[r].sweep_end, sender_gap(), DIRECTED[r].kind,
                    DIRECTED[r].report);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle(6);
      if (phase == 0) begin
        thr_v = 0;
        floor_v = 0;
        minw_v = 0;
        maxobj_v = 1;
      end else if (phase == 1) begin
        thr_v = 4095;
        floor_v = 4095;
        minw_v = 180;
        maxobj_v = 31;
      end else begin
        thr_v    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 500);
        floor_v  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 600);
        minw_v   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 180) : $urandom_range(0, 12);
        maxobj_v = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 31);
      end
      write_register(REG_EDGE_THRESHOLD, thr_v);
      write_register(REG_SAMPLE_FLOOR, floor_v);
      write_register(REG_MIN_WIDTH, minw_v);
      write_register(REG_MAX_OBJECTS, maxobj_v);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0) begin
          // Unstructured items with stray sweep flags.
          n = $urandom_range(1, 8);
          repeat (n) begin
            send_sample(ANGLE_W'($urandom_range(0, 180)), SAMPLE_W'($urandom_range(0, 4095)),
                        $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0, sender_gap(),
                        ROW_ITEM, NO_REPORT);
          end
          sent += n;
        end else begin
          // A sweep over a background with plateaus that stand for objects.
          len = $urandom_range(6, 40);
          backwards = ($urandom_range(0, 7) == 0);
          ang = backwards ? $urandom_range(120, 180) : $urandom_range(0, 60);
          bg = $urandom_range(0, 1200);
          top = bg + $urandom_range(0, 2900);
          if (top > 4095) begin
            top = 4095;
          end
          on_object = 1'b0;
          burst = ($urandom_range(0, 3) == 0);
          with_start = ($urandom_range(0, 9) != 0);
          with_end = ($urandom_range(0, 9) != 0);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 5) == 0) begin
              on_object = !on_object;
            end
            level = (on_object ? top : bg) + $urandom_range(0, 80) - 40;
            if (level < 0) begin
              level = 0;
            end else if (level > 4095) begin
              level = 4095;
            end
            send_sample(ang[ANGLE_W-1:0], level[SAMPLE_W-1:0], with_start && k == 0,
                        with_end && k == len - 1, burst ? 0 : sender_gap(),
                        ROW_ITEM, NO_REPORT);
            step = $urandom_range(0, 4);
            ang = backwards ? ang - step : ang + step;
            if (ang < 0) begin
              ang = 0;
            end else if (ang > 180) begin
              ang = 180;
            end
          end
          sent += len;
        end
        // Now and then the sender holds off until every report is in.
        if ($urandom_range(0, 14) == 0) begin
          settle(1);
        end
      end
    end

    settle(20);
    if (error_count == 0) begin
      $display("PASS scan_object_edge_detector");
    end else begin
      $display("FAIL scan_object_edge_detector");
    end
    $finish;
  end

endmodule
